// ----- hw/rtl/i2cmc_pkg.sv -----
`timescale 1ns / 1ps

package i2cmc_pkg;

  // Command codes carried in the func field of an input word.
  localparam logic [2:0] FUNC_NONE      = 3'd0;
  localparam logic [2:0] FUNC_START     = 3'd1;
  localparam logic [2:0] FUNC_WRITE     = 3'd2;
  localparam logic [2:0] FUNC_READ      = 3'd3;
  localparam logic [2:0] FUNC_STOP      = 3'd4;
  localparam logic [2:0] FUNC_REG_WRITE = 3'd5;
  localparam logic [2:0] FUNC_REG_READ  = 3'd6;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] addr7;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       ack_after_read;
    logic       scl_in;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       acked;
    logic [7:0] read_data;
  } out_t;

endpackage

// ----- hw/rtl/i2c_master_controller_core.sv -----
`timescale 1ns / 1ps

// I2C master bit-level controller.
// The input channel carries one word per bit-timing tick: the sampled SCL and
// SDA levels and, while the controller is idle, a command (start, write byte,
// read byte, stop, register write, register read). Commands that arrive while
// a command is in progress are ignored.
// The output channel returns exactly one word per accepted input word: the
// open-drain pull-low controls for SCL and SDA, busy and done flags, the ACK
// status and the last received byte.
// The result word of an accepted word is registered and is visible on the
// output right after the edge that accepts it. Throughput is one word per
// cycle while the receiver keeps up, set by the single state update per tick.
// The result sits in an output register; a new input word is taken whenever
// that register is empty or is being drained in the same cycle, so a stalled
// receiver stalls the input side only while a result is still waiting.
// Reset clears the controller to idle with both lines released, all held
// bytes and the status cleared, and the output register empty.
module i2c_master_controller_core
  import i2cmc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  // Bus sequencing phases. Codes above the last member are unreachable and
  // fall back to idle.
  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST1    = 5'd1,
    PH_ST2    = 5'd2,
    PH_ST3    = 5'd3,
    PH_SP1    = 5'd4,
    PH_SPWAIT = 5'd5,
    PH_SPHOLD = 5'd6,
    PH_SPEND  = 5'd7,
    PH_WBHI   = 5'd8,
    PH_WBLO   = 5'd9,
    PH_WAREL  = 5'd10,
    PH_WAWAIT = 5'd11,
    PH_WAHOLD = 5'd12,
    PH_WAEND  = 5'd13,
    PH_RBHI   = 5'd14,
    PH_RBLO   = 5'd15,
    PH_RASET  = 5'd16,
    PH_RAHI   = 5'd17,
    PH_RALO   = 5'd18
  } phase_e;

  // Next primitive to launch once the current phase has been handled.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_STOP,
    ACT_WRITE,
    ACT_READ,
    ACT_FINISH
  } act_e;

  // Transaction steps of the register commands.
  localparam logic [3:0] TX_PRIM     = 4'd0;
  localparam logic [3:0] TX_W_ADDR   = 4'd1;
  localparam logic [3:0] TX_W_REG    = 4'd2;
  localparam logic [3:0] TX_W_DATA   = 4'd3;
  localparam logic [3:0] TX_W_STOP   = 4'd4;
  localparam logic [3:0] TX_R_ADDR   = 4'd6;
  localparam logic [3:0] TX_R_REG    = 4'd7;
  localparam logic [3:0] TX_R_RSTART = 4'd8;
  localparam logic [3:0] TX_R_ADDRR  = 4'd9;
  localparam logic [3:0] TX_R_READ   = 4'd10;
  localparam logic [3:0] TX_R_STOP   = 4'd11;
  localparam logic [3:0] TX_R_DONE   = 4'd12;
  localparam logic [3:0] TX_FAIL     = 4'd13;

  phase_e     phase_q, phase_d;
  logic [2:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] txn_q, txn_d;
  logic [6:0] addr_q, addr_d;
  logic [7:0] reg_q, reg_d;
  logic [7:0] data_q, data_d;
  logic       ack_hold_q, ack_hold_d;
  logic       ack_stat_q, ack_stat_d;
  logic [7:0] rx_q, rx_d;
  logic       scl_drv_q, scl_drv_d;
  logic       sda_drv_q, sda_drv_d;
  logic       out_valid_q;
  out_t       out_q, out_d;

  logic       accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    act_e       act;
    logic [7:0] act_byte;
    logic       act_ack;
    logic       adv;
    logic       ok;

    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    txn_d      = txn_q;
    addr_d     = addr_q;
    reg_d      = reg_q;
    data_d     = data_q;
    ack_hold_d = ack_hold_q;
    ack_stat_d = ack_stat_q;
    rx_d       = rx_q;
    scl_drv_d  = scl_drv_q;
    sda_drv_d  = sda_drv_q;
    act        = ACT_NONE;
    act_byte   = in_i.write_data;
    act_ack    = in_i.ack_after_read;
    adv        = 1'b0;
    ok         = 1'b1;

    unique case (phase_q)
      PH_IDLE: begin
        unique case (in_i.func) inside
          FUNC_REG_WRITE, FUNC_REG_READ: begin
            addr_d     = in_i.addr7;
            reg_d      = in_i.reg_addr;
            data_d     = in_i.write_data;
            ack_stat_d = 1'b1;
            txn_d      = (in_i.func == FUNC_REG_WRITE) ? TX_W_ADDR : TX_R_ADDR;
            act        = ACT_START;
          end
          FUNC_START: begin
            txn_d = TX_PRIM;
            act   = ACT_START;
          end
          FUNC_WRITE: begin
            txn_d = TX_PRIM;
            act   = ACT_WRITE;
          end
          FUNC_READ: begin
            txn_d = TX_PRIM;
            act   = ACT_READ;
          end
          FUNC_STOP: begin
            txn_d = TX_PRIM;
            act   = ACT_STOP;
          end
          default: ;
        endcase
      end
      PH_ST1: begin
        sda_drv_d = 1'b1;
        phase_d   = PH_ST2;
      end
      PH_ST2: begin
        scl_drv_d = 1'b1;
        phase_d   = PH_ST3;
      end
      PH_ST3: adv = 1'b1;
      PH_SP1: begin
        scl_drv_d = 1'b0;
        phase_d   = PH_SPWAIT;
      end
      PH_SPWAIT: begin
        if (in_i.scl_in) begin
          phase_d = PH_SPHOLD;
        end
      end
      PH_SPHOLD: begin
        sda_drv_d = 1'b0;
        phase_d   = PH_SPEND;
      end
      PH_SPEND: adv = 1'b1;
      PH_WBHI: begin
        scl_drv_d = 1'b1;
        phase_d   = PH_WBLO;
      end
      PH_WBLO: begin
        shift_d = {shift_q[6:0], 1'b0};
        if (bit_cnt_q == 3'd7) begin
          sda_drv_d = 1'b0;
          phase_d   = PH_WAREL;
        end else begin
          bit_cnt_d = bit_cnt_q + 3'd1;
          sda_drv_d = !shift_q[6];
          scl_drv_d = 1'b0;
          phase_d   = PH_WBHI;
        end
      end
      PH_WAREL: begin
        scl_drv_d = 1'b0;
        phase_d   = PH_WAWAIT;
      end
      PH_WAWAIT: begin
        if (in_i.scl_in) begin
          phase_d = PH_WAHOLD;
        end
      end
      PH_WAHOLD: begin
        ack_hold_d = !in_i.sda_in;
        scl_drv_d  = 1'b1;
        phase_d    = PH_WAEND;
      end
      PH_WAEND: begin
        if (txn_q == TX_PRIM) begin
          ack_stat_d = ack_hold_q;
        end
        adv = 1'b1;
        ok  = ack_hold_q;
      end
      PH_RBHI: begin
        shift_d   = {shift_q[6:0], in_i.sda_in};
        scl_drv_d = 1'b1;
        phase_d   = PH_RBLO;
      end
      PH_RBLO: begin
        if (bit_cnt_q == 3'd7) begin
          sda_drv_d = ack_hold_q;
          phase_d   = PH_RASET;
        end else begin
          bit_cnt_d = bit_cnt_q + 3'd1;
          scl_drv_d = 1'b0;
          phase_d   = PH_RBHI;
        end
      end
      PH_RASET: begin
        scl_drv_d = 1'b0;
        phase_d   = PH_RAHI;
      end
      PH_RAHI: begin
        scl_drv_d = 1'b1;
        phase_d   = PH_RALO;
      end
      PH_RALO: begin
        sda_drv_d = 1'b0;
        rx_d      = shift_q;
        adv       = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
        txn_d   = TX_PRIM;
      end
    endcase

    // Register command sequencing: pick the next primitive, or bail out to a
    // stop on the first missing acknowledge.
    if (adv) begin
      unique case (txn_q) inside
        TX_W_ADDR: begin
          txn_d    = TX_W_REG;
          act      = ACT_WRITE;
          act_byte = {addr_q, 1'b0};
        end
        TX_W_REG, TX_W_DATA, TX_W_STOP, TX_R_REG, TX_R_RSTART, TX_R_READ: begin
          if (!ok) begin
            ack_stat_d = 1'b0;
            txn_d      = TX_FAIL;
            act        = ACT_STOP;
          end else begin
            txn_d = txn_q + 4'd1;
            unique case (txn_q) inside
              TX_W_REG, TX_R_REG: begin
                act      = ACT_WRITE;
                act_byte = reg_q;
              end
              TX_W_DATA: begin
                act      = ACT_WRITE;
                act_byte = data_q;
              end
              TX_W_STOP:   act = ACT_STOP;
              TX_R_RSTART: act = ACT_START;
              default: begin
                act     = ACT_READ;
                act_ack = 1'b0;
              end
            endcase
          end
        end
        TX_R_ADDR: begin
          txn_d    = TX_R_REG;
          act      = ACT_WRITE;
          act_byte = {addr_q, 1'b0};
        end
        TX_R_ADDRR: begin
          txn_d    = TX_R_READ;
          act      = ACT_WRITE;
          act_byte = {addr_q, 1'b1};
        end
        TX_R_STOP: begin
          txn_d = TX_R_DONE;
          act   = ACT_STOP;
        end
        default: begin
          txn_d = TX_PRIM;
          act   = ACT_FINISH;
        end
      endcase
    end

    unique case (act)
      ACT_START: begin
        sda_drv_d = 1'b0;
        scl_drv_d = 1'b0;
        phase_d   = PH_ST1;
      end
      ACT_STOP: begin
        sda_drv_d = 1'b1;
        phase_d   = PH_SP1;
      end
      ACT_WRITE: begin
        shift_d   = act_byte;
        bit_cnt_d = 3'd0;
        sda_drv_d = !act_byte[7];
        scl_drv_d = 1'b0;
        phase_d   = PH_WBHI;
      end
      ACT_READ: begin
        ack_hold_d = act_ack;
        shift_d    = 8'd0;
        bit_cnt_d  = 3'd0;
        sda_drv_d  = 1'b0;
        scl_drv_d  = 1'b0;
        phase_d    = PH_RBHI;
      end
      ACT_FINISH: phase_d = PH_IDLE;
      default: ;
    endcase

    out_d.scl_pull_low = scl_drv_d;
    out_d.sda_pull_low = sda_drv_d;
    out_d.busy_res     = (phase_d != PH_IDLE);
    out_d.done_res     = (act == ACT_FINISH);
    out_d.acked        = ack_stat_d;
    out_d.read_data    = rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      txn_q       <= TX_PRIM;
      addr_q      <= '0;
      reg_q       <= '0;
      data_q      <= '0;
      ack_hold_q  <= 1'b0;
      ack_stat_q  <= 1'b0;
      rx_q        <= '0;
      scl_drv_q   <= 1'b0;
      sda_drv_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        bit_cnt_q  <= bit_cnt_d;
        shift_q    <= shift_d;
        txn_q      <= txn_d;
        addr_q     <= addr_d;
        reg_q      <= reg_d;
        data_q     <= data_d;
        ack_hold_q <= ack_hold_d;
        ack_stat_q <= ack_stat_d;
        rx_q       <= rx_d;
        scl_drv_q  <= scl_drv_d;
        sda_drv_q  <= sda_drv_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- hw/rtl/i2cmc_checker.sv -----
`timescale 1ns / 1ps

module i2cmc_checker
  import i2cmc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  // Every accepted word yields a result word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // The input side only stalls while a result is waiting and not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // A finishing command always leaves the controller idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.done_res |-> !out_o.busy_res)
    else $error("done reported while still busy");

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

endmodule

bind i2c_master_controller_core i2cmc_checker u_i2cmc_checker (.*);
